[design/ialu_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and operation codes for the iterative integer ALU.
// No dependencies; every design file of the block refers to it by scoped names, and the bench imports it.
package ialu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int FUNC_W     = 3;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [FUNC_W-1:0]     t_func;

    // Operation codes carried on the input tuser.
    localparam t_func FN_ADD = 3'd0;
    localparam t_func FN_SUB = 3'd1;
    localparam t_func FN_MUL = 3'd2;
    localparam t_func FN_DIV = 3'd3;
    localparam t_func FN_POW = 3'd4;

    localparam t_cnt LAST_STEP = t_cnt'(DATA_WIDTH - 1);

endpackage

[design/integer_alu_add_sub_mul_div_pow_unit.sv]
`timescale 1ns / 1ps
// Top level of the iterative integer ALU: stream ports, operation sequencer
// and result register. Depends on ialu_pkg, ialu_addsub, ialu_mul, ialu_div.
//
//  Channel  | Direction | tdata (low bit up)        | tuser
//  ---------+-----------+---------------------------+-------------
//  s_axis   | in        | operand_a, operand_b      | func
//  m_axis   | out       | result, remainder         | div_by_zero
//
// Each item is worked on alone, bit-serially. Add, subtract, multiply and divide pass through
// issue, 32 serial steps, finish and output load; a divide by zero or an unused code goes
// from issue straight to finish. Power runs 32 rounds with two multipliers side by side,
// which sets the worst case. Reset is synchronous, active low, and leaves the block idle
// and empty. A finished item waits in the output register, unchanged while stalled, as the
// next one is accepted and worked on.
module integer_alu_add_sub_mul_div_pow_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*ialu_pkg::DATA_WIDTH-1:0] s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
    input  ialu_pkg::t_func                   s_axis_tuser,  // [2:0] func
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*ialu_pkg::DATA_WIDTH-1:0] m_axis_tdata,  // [31:0] result, [63:32] remainder
    output logic [0:0]                        m_axis_tuser   // [0] div_by_zero
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_ISSUE     = 3'd1;
    localparam logic [2:0] ST_WAIT      = 3'd2;
    localparam logic [2:0] ST_POW_ISSUE = 3'd3;
    localparam logic [2:0] ST_POW_WAIT  = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;

    localparam int W = ialu_pkg::DATA_WIDTH;

    logic [2:0]        r_state, n_state;
    ialu_pkg::t_func   r_func;
    ialu_pkg::t_data   r_opa, r_opb;

    // Square-and-multiply registers: running product, running square and
    // the exponent, which shifts right one bit per round.
    ialu_pkg::t_data   r_acc, n_acc;
    ialu_pkg::t_data   r_sq, n_sq;
    ialu_pkg::t_data   r_exp, n_exp;
    ialu_pkg::t_cnt    r_round, n_round;

    // Finished result, waiting for room in the output register.
    ialu_pkg::t_data   r_res, n_res;
    ialu_pkg::t_data   r_rem, n_rem;
    logic              r_dz, n_dz;

    logic              r_m_valid, n_m_valid;
    ialu_pkg::t_data   r_m_res, r_m_rem;
    logic              r_m_dz;

    logic              w_in_fire;
    logic              w_out_load;
    logic              w_is_pow;

    logic              w_as_start, w_as_done;
    ialu_pkg::t_data   w_as_sum;
    logic              w_m0_start, w_m0_done;
    logic              w_m1_start, w_m1_done;
    ialu_pkg::t_data   w_m0_a, w_m0_b, w_m0_p, w_m1_p;
    logic              w_dv_start, w_dv_done;
    ialu_pkg::t_data   w_dv_quo, w_dv_rem;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_is_pow      = (r_func == ialu_pkg::FN_POW);

    // The finished item moves into the output register once it is empty or
    // its current item is being taken.
    assign w_out_load = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    // Unit start pulses.
    assign w_as_start = (r_state == ST_ISSUE) &&
                        ((r_func == ialu_pkg::FN_ADD) || (r_func == ialu_pkg::FN_SUB));
    assign w_m0_start = ((r_state == ST_ISSUE) && (r_func == ialu_pkg::FN_MUL)) ||
                        (r_state == ST_POW_ISSUE);
    assign w_m1_start = (r_state == ST_POW_ISSUE);
    assign w_dv_start = (r_state == ST_ISSUE) && (r_func == ialu_pkg::FN_DIV) &&
                        (r_opb != '0);

    // The first multiplier serves plain multiply and the accumulate step of
    // power; the second squares the base during power.
    assign w_m0_a = w_is_pow ? r_acc : r_opa;
    assign w_m0_b = w_is_pow ? r_sq  : r_opb;

    ialu_addsub u_addsub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_as_start),
        .i_sub   (r_func == ialu_pkg::FN_SUB),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_done  (w_as_done),
        .o_sum   (w_as_sum)
    );

    ialu_mul u_mul_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_m0_start),
        .i_a       (w_m0_a),
        .i_b       (w_m0_b),
        .o_done    (w_m0_done),
        .o_product (w_m0_p)
    );

    ialu_mul u_mul_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_m1_start),
        .i_a       (r_sq),
        .i_b       (r_sq),
        .o_done    (w_m1_done),
        .o_product (w_m1_p)
    );

    ialu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_dv_start),
        .i_dividend  (r_opa),
        .i_divisor   (r_opb),
        .o_done      (w_dv_done),
        .o_quotient  (w_dv_quo),
        .o_remainder (w_dv_rem)
    );

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_sq      = r_sq;
        n_exp     = r_exp;
        n_round   = r_round;
        n_res     = r_res;
        n_rem     = r_rem;
        n_dz      = r_dz;
        n_m_valid = r_m_valid;

        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        if (w_out_load) begin
            n_m_valid = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_res = '0;
                n_rem = '0;
                n_dz  = 1'b0;
                case (r_func)
                    ialu_pkg::FN_ADD, ialu_pkg::FN_SUB, ialu_pkg::FN_MUL: begin
                        n_state = ST_WAIT;
                    end
                    ialu_pkg::FN_DIV: begin
                        if (r_opb == '0) begin
                            // Zero divisor: all-ones quotient, dividend as remainder.
                            n_res   = '1;
                            n_rem   = r_opa;
                            n_dz    = 1'b1;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_WAIT;
                        end
                    end
                    ialu_pkg::FN_POW: begin
                        n_acc   = W'(1);
                        n_sq    = r_opa;
                        n_exp   = r_opb;
                        n_round = '0;
                        n_state = ST_POW_ISSUE;
                    end
                    default: begin
                        // Unused codes give an all-zero result.
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_WAIT: begin
                case (r_func)
                    ialu_pkg::FN_MUL: begin
                        if (w_m0_done) begin
                            n_res   = w_m0_p;
                            n_state = ST_DONE;
                        end
                    end
                    ialu_pkg::FN_DIV: begin
                        if (w_dv_done) begin
                            n_res   = w_dv_quo;
                            n_rem   = w_dv_rem;
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        if (w_as_done) begin
                            n_res   = w_as_sum;
                            n_state = ST_DONE;
                        end
                    end
                endcase
            end
            ST_POW_ISSUE: begin
                n_state = ST_POW_WAIT;
            end
            ST_POW_WAIT: begin
                // Both multipliers start together and finish together.
                if (w_m0_done && w_m1_done) begin
                    if (r_exp[0]) begin
                        n_acc = w_m0_p;
                    end
                    n_sq    = w_m1_p;
                    n_exp   = r_exp >> 1;
                    n_round = r_round + 1'b1;
                    if (r_round == ialu_pkg::LAST_STEP) begin
                        n_res   = r_exp[0] ? w_m0_p : r_acc;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_POW_ISSUE;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
        if (w_in_fire) begin
            r_func <= s_axis_tuser;
            r_opa  <= s_axis_tdata[W-1:0];
            r_opb  <= s_axis_tdata[2*W-1:W];
        end
        r_acc   <= n_acc;
        r_sq    <= n_sq;
        r_exp   <= n_exp;
        r_round <= n_round;
        r_res   <= n_res;
        r_rem   <= n_rem;
        r_dz    <= n_dz;
        if (w_out_load) begin
            r_m_res <= r_res;
            r_m_rem <= r_rem;
            r_m_dz  <= r_dz;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_rem, r_m_res};
    assign m_axis_tuser  = r_m_dz;

endmodule

[design/ialu_addsub.sv]
`timescale 1ns / 1ps
// Bit-serial adder/subtractor: one sum bit per cycle, carry held in a flop.
// Depends on ialu_pkg.
module ialu_addsub (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_sub,
    input  ialu_pkg::t_data i_a,
    input  ialu_pkg::t_data i_b,
    output logic            o_done,
    output ialu_pkg::t_data o_sum
);

    ialu_pkg::t_data r_a, r_b, r_sum;
    ialu_pkg::t_data n_a, n_b, n_sum;
    logic            r_carry, n_carry;
    logic            r_sub;
    ialu_pkg::t_cnt  r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic            w_bbit;
    logic            w_sbit;

    assign w_bbit = r_b[0] ^ r_sub;
    assign w_sbit = r_a[0] ^ w_bbit ^ r_carry;

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_sum   = r_sum;
        n_carry = r_carry;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_a     = i_a;
            n_b     = i_b;
            n_carry = i_sub;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            // The sum word fills from the top, so it is aligned once the last bit is in.
            n_sum   = {w_sbit, r_sum[ialu_pkg::DATA_WIDTH-1:1]};
            n_carry = (r_a[0] & w_bbit) | (r_carry & (r_a[0] ^ w_bbit));
            n_a     = r_a >> 1;
            n_b     = r_b >> 1;
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == ialu_pkg::LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_sum   <= n_sum;
        r_carry <= n_carry;
        r_cnt   <= n_cnt;
        if (i_start) begin
            r_sub <= i_sub;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

[design/ialu_mul.sv]
`timescale 1ns / 1ps
// Shift-add multiplier keeping the low word of the product, one multiplier
// bit per cycle. Depends on ialu_pkg.
module ialu_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ialu_pkg::t_data i_a,
    input  ialu_pkg::t_data i_b,
    output logic            o_done,
    output ialu_pkg::t_data o_product
);

    ialu_pkg::t_data r_acc, r_mcand, r_mplier;
    ialu_pkg::t_data n_acc, n_mcand, n_mplier;
    ialu_pkg::t_cnt  r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_start) begin
            n_acc    = '0;
            n_mcand  = i_a;
            n_mplier = i_b;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == ialu_pkg::LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

[design/ialu_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle. The divisor must
// be non-zero; the caller handles a zero divisor. Depends on ialu_pkg.
module ialu_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ialu_pkg::t_data i_dividend,
    input  ialu_pkg::t_data i_divisor,
    output logic            o_done,
    output ialu_pkg::t_data o_quotient,
    output ialu_pkg::t_data o_remainder
);

    ialu_pkg::t_data                r_rem, r_quo, r_dvs;
    ialu_pkg::t_data                n_rem, n_quo;
    ialu_pkg::t_cnt                 r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [ialu_pkg::DATA_WIDTH:0]  w_part;
    logic [ialu_pkg::DATA_WIDTH:0]  w_trial;

    // Partial remainder with the next dividend bit shifted in, then a trial subtract.
    assign w_part  = {r_rem, r_quo[ialu_pkg::DATA_WIDTH-1]};
    assign w_trial = w_part - {1'b0, r_dvs};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[ialu_pkg::DATA_WIDTH]) begin
                n_rem = w_trial[ialu_pkg::DATA_WIDTH-1:0];
                n_quo = {r_quo[ialu_pkg::DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = w_part[ialu_pkg::DATA_WIDTH-1:0];
                n_quo = {r_quo[ialu_pkg::DATA_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == ialu_pkg::LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[test/tb_integer_alu_add_sub_mul_div_pow_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for the iterative integer ALU: random and corner-case operations
// are streamed in, and every result is checked against a behavioural ALU model held here.
// Depends on ialu_pkg and the integer_alu_add_sub_mul_div_pow_unit design.
module tb_integer_alu_add_sub_mul_div_pow_unit;
    import ialu_pkg::*;

    // Codes 5 to 7 are not assigned to any operation and must give an all-zero result.
    localparam t_func FN_RSVD_FIRST = 3'd5;
    localparam t_func FN_RSVD_LAST  = 3'd7;
    localparam t_data ALL_ONES      = {DATA_WIDTH{1'b1}};
    localparam t_data TOP_BIT       = t_data'(1) << (DATA_WIDTH - 1);

    // One operation as it travels on the input side.
    typedef struct packed {
        t_func func;
        t_data a;
        t_data b;
    } alu_op_t;

    // The three fields of one result item.
    typedef struct packed {
        t_data value;
        t_data rem;
        logic  dz;
    } alu_res_t;

    typedef struct {
        alu_op_t  op;
        alu_res_t want;
    } alu_job_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;    // [31:0] operand_a, [63:32] operand_b
    logic [2:0]  s_axis_tuser  = '0;    // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // [31:0] result, [63:32] remainder
    logic [0:0]  m_axis_tuser;          // [0] div_by_zero

    alu_op_t  ops_to_send[$];   // operations not yet offered to the block
    alu_job_t awaited[$];       // accepted operations whose result is still due
    alu_op_t  op_on_bus;
    alu_job_t job;
    int       ops_accepted  = 0;
    int       results_taken = 0;
    int       error_count   = 0;

    integer_alu_add_sub_mul_div_pow_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioural ALU: every result wraps at the data width, and power is done by
    // square-and-multiply over all exponent bits, so a zero exponent gives one.
    function automatic alu_res_t alu_compute(alu_op_t op);
        alu_res_t r;
        t_data    acc;
        t_data    sq;
        r = '0;
        case (op.func)
            FN_ADD: r.value = op.a + op.b;
            FN_SUB: r.value = op.a - op.b;
            FN_MUL: r.value = op.a * op.b;
            FN_DIV: begin
                if (op.b == '0) begin
                    // A zero divisor flags the error and hands the dividend back.
                    r.value = ALL_ONES;
                    r.rem   = op.a;
                    r.dz    = 1'b1;
                end else begin
                    r.value = op.a / op.b;
                    r.rem   = op.a % op.b;
                end
            end
            FN_POW: begin
                acc = t_data'(1);
                sq  = op.a;
                for (int i = 0; i < DATA_WIDTH; i++) begin
                    if (op.b[i]) begin
                        acc = acc * sq;
                    end
                    sq = sq * sq;
                end
                r.value = acc;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, alu_op_t op, t_data got, t_data want);
        error_count++;
        if (error_count <= 100) begin
            $display("%0t ns: %s wrong for func %0d, a %h, b %h: got %h, want %h",
                     $time, field, op.func, op.a, op.b, got, want);
        end
    endtask

    task automatic queue_op(t_func func, t_data a, t_data b);
        ops_to_send.insert(ops_to_send.size(), alu_op_t'{func, a, b});
    endtask

    // Operand mix: wide random values, small values, values at the edges and
    // values of random magnitude, so that carries, borrows and quotients vary.
    function automatic t_data rand_operand();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            return t_data'($urandom);
        end else if (pick < 65) begin
            return t_data'($urandom_range(15));
        end else if (pick < 80) begin
            case ($urandom_range(4))
                0:       return '0;
                1:       return t_data'(1);
                2:       return ALL_ONES;
                3:       return TOP_BIT;
                default: return ~TOP_BIT;
            endcase
        end
        return t_data'($urandom) >> $urandom_range(DATA_WIDTH - 1);
    endfunction

    // Both sides pause at random, with a chance of 12 in a hundred on each try, except while
    // their own count is in a window where they run flat out.
    function automatic bit take_gap(int count);
        return !(count >= 250 && count < 350) && ($urandom_range(99) < 12);
    endfunction

    // Input side: an item stays on the bus until accepted; its expected result is
    // queued at the edge where the handshake completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited.insert(awaited.size(), alu_job_t'{op_on_bus, alu_compute(op_on_bus)});
                ops_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (ops_to_send.size() != 0 && !take_gap(ops_accepted)) begin
                    op_on_bus = ops_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {op_on_bus.b, op_on_bus.a};
                    s_axis_tuser  <= op_on_bus.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: each accepted result is checked against the oldest due item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_taken++;
                if (awaited.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_axis_tdata[31:0], '0);
                end else begin
                    job = awaited.pop_front();
                    if (m_axis_tdata[31:0] !== job.want.value) begin
                        report_mismatch("result", job.op, m_axis_tdata[31:0], job.want.value);
                    end
                    if (m_axis_tdata[63:32] !== job.want.rem) begin
                        report_mismatch("remainder", job.op, m_axis_tdata[63:32], job.want.rem);
                    end
                    if (m_axis_tuser[0] !== job.want.dz) begin
                        report_mismatch("div_by_zero", job.op, t_data'(m_axis_tuser[0]),
                                        t_data'(job.want.dz));
                    end
                end
            end
            m_axis_tready <= !take_gap(results_taken);
        end
    end

    initial begin
        int    pick;
        t_func func;

        // Corner cases: wrap-around of each operation, division by zero, zero
        // exponent with a zero base, and the unused operation codes.
        queue_op(FN_ADD, ALL_ONES, t_data'(1));
        queue_op(FN_ADD, ALL_ONES, ALL_ONES);
        queue_op(FN_ADD, '0, '0);
        queue_op(FN_SUB, '0, t_data'(1));
        queue_op(FN_SUB, ALL_ONES, ALL_ONES);
        queue_op(FN_MUL, ALL_ONES, ALL_ONES);
        queue_op(FN_MUL, t_data'(32'h0001_0000), t_data'(32'h0001_0000));
        queue_op(FN_MUL, TOP_BIT, '0);
        queue_op(FN_DIV, ALL_ONES, '0);
        queue_op(FN_DIV, '0, '0);
        queue_op(FN_DIV, ALL_ONES, t_data'(1));
        queue_op(FN_DIV, ALL_ONES, ALL_ONES);
        queue_op(FN_DIV, t_data'(7), ALL_ONES);
        queue_op(FN_DIV, ALL_ONES, TOP_BIT);
        queue_op(FN_POW, '0, '0);
        queue_op(FN_POW, t_data'(7), '0);
        queue_op(FN_POW, t_data'(2), t_data'(DATA_WIDTH - 1));
        queue_op(FN_POW, t_data'(2), t_data'(DATA_WIDTH));
        queue_op(FN_POW, ALL_ONES, ALL_ONES);
        queue_op(FN_POW, t_data'(3), ALL_ONES);
        queue_op(FN_RSVD_FIRST, ALL_ONES, ALL_ONES);
        queue_op(FN_RSVD_FIRST + t_func'(1), t_data'($urandom), '0);
        queue_op(FN_RSVD_LAST, t_data'($urandom), t_data'($urandom));

        // Random part; power is kept to about one item in eight because each one
        // runs 32 multiply rounds and holds the block the longest.
        repeat (540) begin
            pick = $urandom_range(99);
            if (pick < 20)      func = FN_ADD;
            else if (pick < 40) func = FN_SUB;
            else if (pick < 60) func = FN_MUL;
            else if (pick < 82) func = FN_DIV;
            else if (pick < 94) func = FN_POW;
            else                func = t_func'($urandom_range(FN_RSVD_LAST, FN_RSVD_FIRST));
            queue_op(func, rand_operand(), rand_operand());
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_to_send.size() != 0 || s_axis_tvalid || awaited.size() != 0) begin
            @(posedge i_clk);
        end
        // Allow time for any stray result to show up after the last one due.
        repeat (50) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
